// ===== src/ewma_mean_variance_threshold_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the block.
// Both macros sample on the rising edge of clock and are muted while reset
// is high.
// ---------------------------------------------------------------------------
`ifndef EWMA_MEAN_VARIANCE_THRESHOLD_MACROS_SVH
`define EWMA_MEAN_VARIANCE_THRESHOLD_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EWMV_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EWMV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ewmv_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ewmv_pkg
// Shared types and constants of the moving mean / variance threshold block.
// ---------------------------------------------------------------------------
package ewmv_pkg;

   // fixed field widths
   localparam int TICK_W    = 64;
   localparam int VAR_W     = 64;
   localparam int DEV_W     = 32;
   localparam int WEIGHT_W  = 16;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 32;

   // accumulator for the weighted sums: (65536 * 2^64) plus rounding
   localparam int ACC_W     = 82;

   // one restoring step per result bit of the square root
   localparam int ROOT_STEPS = 32;
   localparam int ROOT_CNT_W = 5;

   // alpha of one in Q0.16, needs a 17th bit
   localparam logic [16:0] ONE_Q16 = 17'h10000;

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_SMOOTHING = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MULTIPLIER = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WARMUP    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FLOOR     = 4'd3;

   // multiplier operand selects; the six accumulated partial products come
   // first, odd codes land in the upper half of the accumulator
   localparam int MUL_SEL_W = 3;
   localparam logic [MUL_SEL_W-1:0] MUL_MEAN_LO = 3'd0;
   localparam logic [MUL_SEL_W-1:0] MUL_MEAN_HI = 3'd1;
   localparam logic [MUL_SEL_W-1:0] MUL_VAR_LO  = 3'd2;
   localparam logic [MUL_SEL_W-1:0] MUL_VAR_HI  = 3'd3;
   localparam logic [MUL_SEL_W-1:0] MUL_SQ_LO   = 3'd4;
   localparam logic [MUL_SEL_W-1:0] MUL_SQ_HI   = 3'd5;
   localparam logic [MUL_SEL_W-1:0] MUL_MAG_SQ  = 3'd6;
   localparam logic [MUL_SEL_W-1:0] MUL_LIMIT   = 3'd7;

   // commands from the controller to the datapath
   typedef struct packed {
      logic                 ld;        // capture input word, arm square root
      logic                 diff;      // deviation from the current mean
      logic                 mul_go;    // register one product
      logic [MUL_SEL_W-1:0] mul_sel;   // operand pair
      logic                 sq_ld;     // capture squared deviation
      logic                 acc_go;    // add product into accumulator
      logic                 mean_upd;  // commit new mean
      logic                 var_upd;   // commit new variance and count
      logic                 root_step; // one square root step
      logic                 dev_ld;    // floor the root
      logic                 out_ld;    // load the output word
   } ewmv_cmd_type;

endpackage

// ===== src/ewma_mean_variance_threshold.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ewma_mean_variance_threshold
// Exponentially weighted mean and variance tracker with a mean + n*sigma
// threshold, reported on request.
// ---------------------------------------------------------------------------
//
//   channel   direction  fields (lowest bit first)
//   --------  ---------  ----------------------------------------------------
//   req_      in         tuser: action; tdata: sample, tick_number
//   rsp_      out        tdata: report_tick, mean_value, deviation,
//                               limit_value, warm
//   csr_      in         index 0 smoothing, 1 multiplier, 2 warmup, 3 floor
//
//   A sample word occupies the block from acceptance through the
//   deviation step, the squared deviation and six passes through the one
//   shared 32x32 multiplier, each followed by an accumulate.
//   A tick word occupies it through the 32 steps of the bit-serial
//   square root, then floor, multiply and clip.
//   The finished report waits in the output register, so the next word is
//   taken while it is held; a tick stalls before its output load only while
//   the previous report still waits.
//   Synchronous active-high reset restores the register defaults and zeroes
//   mean, variance and count. csr_ready is always high.
// ---------------------------------------------------------------------------
module ewma_mean_variance_threshold #(
   parameter int SAMPLE_WIDTH = 32,
   localparam int REQ_W = ((SAMPLE_WIDTH + 64 + 7) / 8) * 8,
   localparam int RSP_W = ((2 * SAMPLE_WIDTH + 97 + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // request words
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_W-1:0]                  req_tdata,   // sample, tick_number
   input  logic                              req_tuser,   // action (1 = tick)
   // report words
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_W-1:0]                  rsp_tdata,   // report_tick, mean_value,
                                                          // deviation, limit_value, warm
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ewmv_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ewmv_pkg::CSR_DAT_W-1:0]    csr_data
);
   import ewmv_pkg::*;

   localparam int PAD_W = RSP_W - (2 * SAMPLE_WIDTH + TICK_W + DEV_W + 1);

   ewmv_cmd_type            cmd;
   logic [TICK_W-1:0]       out_tick;
   logic [SAMPLE_WIDTH-1:0] out_mean, out_limit;
   logic [DEV_W-1:0]        out_dev;
   logic                    out_warm;

   // register writes are taken at once; software writes only when idle, which the block does not enforce
   assign csr_ready = 1'b1;

   // sequencer: one word in flight
   ewmv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // arithmetic and state
   ewmv_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_we    (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_sample (req_tdata[SAMPLE_WIDTH-1:0]),
      .in_tick   (req_tdata[SAMPLE_WIDTH +: TICK_W]),
      .out_tick  (out_tick),
      .out_mean  (out_mean),
      .out_dev   (out_dev),
      .out_limit (out_limit),
      .out_warm  (out_warm)
   );

   // pack the report, first field lowest, zero fill to whole bytes
   assign rsp_tdata = {{PAD_W{1'b0}}, out_warm, out_limit, out_dev, out_mean, out_tick};

endmodule

// ===== src/ewmv_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ewmv_ctrl
// Sequencer: walks each sample or tick through the datapath and owns the
// output word valid flag.
// ---------------------------------------------------------------------------
module ewmv_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output ewmv_pkg::ewmv_cmd_type cmd
);
   import ewmv_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DIFF    = 4'd1;
   localparam logic [3:0] S_SQ_MUL  = 4'd2;
   localparam logic [3:0] S_SQ_LOAD = 4'd3;
   localparam logic [3:0] S_MUL     = 4'd4;
   localparam logic [3:0] S_ACC     = 4'd5;
   localparam logic [3:0] S_MEAN    = 4'd6;
   localparam logic [3:0] S_VAR     = 4'd7;
   localparam logic [3:0] S_ROOT    = 4'd8;
   localparam logic [3:0] S_FLOOR   = 4'd9;
   localparam logic [3:0] S_LIM_MUL = 4'd10;
   localparam logic [3:0] S_LIMIT   = 4'd11;

   logic [3:0]            state_ff, state_in;
   logic [MUL_SEL_W-1:0]  step_ff, step_in;
   logic [ROOT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  valid_ff, valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.mul_sel = step_ff;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_tvalid) begin
               cmd.ld   = 1'b1;
               state_in = req_tuser ? S_ROOT : S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_SQ_MUL;
         end
         S_SQ_MUL: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_MAG_SQ;
            state_in    = S_SQ_LOAD;
         end
         S_SQ_LOAD: begin
            cmd.sq_ld = 1'b1;
            step_in   = MUL_MEAN_LO;
            state_in  = S_MUL;
         end
         S_MUL: begin
            cmd.mul_go = 1'b1;
            state_in   = S_ACC;
         end
         S_ACC: begin
            cmd.acc_go = 1'b1;
            if (step_ff == MUL_MEAN_HI) begin
               state_in = S_MEAN;
            end else if (step_ff == MUL_SQ_HI) begin
               state_in = S_VAR;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_MEAN: begin
            cmd.mean_upd = 1'b1;
            step_in      = MUL_VAR_LO;
            state_in     = S_MUL;
         end
         S_VAR: begin
            cmd.var_upd = 1'b1;
            state_in    = S_IDLE;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
               state_in = S_FLOOR;
            end
         end
         S_FLOOR: begin
            cmd.dev_ld = 1'b1;
            state_in   = S_LIM_MUL;
         end
         S_LIM_MUL: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_LIMIT;
            state_in    = S_LIMIT;
         end
         S_LIMIT: begin
            // hold until the output register is free or drains this cycle
            if (!valid_ff || rsp_tready) begin
               cmd.out_ld = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_ld) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= MUL_MEAN_LO;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== src/ewmv_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ewmv_datapath
// Estimator state, configuration registers, shared 32x32 multiplier,
// weighted-sum accumulator, bit-serial square root and output word.
// ---------------------------------------------------------------------------
module ewmv_datapath #(
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ewmv_pkg::ewmv_cmd_type               cmd,
   input  logic                                 csr_we,
   input  logic [ewmv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ewmv_pkg::CSR_DAT_W-1:0]       csr_data,
   input  logic [SAMPLE_WIDTH-1:0]              in_sample,
   input  logic [ewmv_pkg::TICK_W-1:0]          in_tick,
   output logic [ewmv_pkg::TICK_W-1:0]          out_tick,
   output logic [SAMPLE_WIDTH-1:0]              out_mean,
   output logic [ewmv_pkg::DEV_W-1:0]           out_dev,
   output logic [SAMPLE_WIDTH-1:0]              out_limit,
   output logic                                 out_warm
);
   import ewmv_pkg::*;

   localparam int DX_W  = SAMPLE_WIDTH + 1;
   localparam int SCL_W = 40;  // (Q8.8 * Q32.0) >> 8
   localparam int SUM_W = ((SAMPLE_WIDTH > SCL_W + 1) ? SAMPLE_WIDTH : SCL_W + 1) + 1;

   // configuration
   logic [WEIGHT_W-1:0] alpha_ff, mult_ff, warmup_ff;
   logic [DEV_W-1:0]    floor_ff;

   // estimator state
   logic [SAMPLE_WIDTH-1:0] mean_ff, mean_in;
   logic [VAR_W-1:0]        var_ff, var_in;
   logic [WEIGHT_W-1:0]     count_ff, count_in;

   // working registers
   logic [SAMPLE_WIDTH-1:0] x_ff;
   logic [TICK_W-1:0]       tick_ff;
   logic [DX_W-1:0]         dx_ff, dx_in, mag_ff, mag_in;
   logic [VAR_W-1:0]        sq_ff, prod_ff, prod_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [VAR_W-1:0]        rad_ff;
   logic [DEV_W+1:0]        rem_ff, rem_in;
   logic [DEV_W-1:0]        root_ff, root_in, dev_ff;

   // output word
   logic [TICK_W-1:0]       o_tick_ff;
   logic [SAMPLE_WIDTH-1:0] o_mean_ff, o_lim_ff, lim_in;
   logic [DEV_W-1:0]        o_dev_ff;
   logic                    o_warm_ff;

   logic [VAR_W-1:0]        mag64;
   logic [16:0]             keep_w;
   logic [31:0]             op_a, op_b;
   logic [ACC_W-1:0]        addend;
   logic signed [ACC_W-1:0] macc, mrnd;
   logic [DEV_W+3:0]        cur, trial, sub;
   logic signed [SUM_W-1:0] lim_sum, smax_ext;

   assign mag64  = {{(VAR_W-DX_W){1'b0}}, mag_ff};
   assign keep_w = ONE_Q16 - {1'b0, alpha_ff};

   // operand select for the shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         MUL_MEAN_LO: begin op_a = {16'd0, alpha_ff};  op_b = mag64[31:0];   end
         MUL_MEAN_HI: begin op_a = {16'd0, alpha_ff};  op_b = mag64[63:32];  end
         MUL_VAR_LO:  begin op_a = {15'd0, keep_w};    op_b = var_ff[31:0];  end
         MUL_VAR_HI:  begin op_a = {15'd0, keep_w};    op_b = var_ff[63:32]; end
         MUL_SQ_LO:   begin op_a = {16'd0, alpha_ff};  op_b = sq_ff[31:0];   end
         MUL_SQ_HI:   begin op_a = {16'd0, alpha_ff};  op_b = sq_ff[63:32];  end
         MUL_MAG_SQ:  begin op_a = mag64[31:0];        op_b = mag64[31:0];   end
         MUL_LIMIT:   begin op_a = {16'd0, mult_ff};   op_b = dev_ff;        end
         default:     begin op_a = '0;                 op_b = '0;            end
      endcase
      prod_in = op_a * op_b;
   end

   // deviation from the old mean and its magnitude
   always_comb begin
      dx_in  = $signed({x_ff[SAMPLE_WIDTH-1], x_ff})
             - $signed({mean_ff[SAMPLE_WIDTH-1], mean_ff});
      mag_in = dx_in[DX_W-1] ? (~dx_in + DX_W'(1)) : dx_in;
   end

   // accumulate; odd selects are upper partial products, which stay below
   // 2^50, so shift their low bits up by 32
   always_comb begin
      if (cmd.mul_sel == MUL_MEAN_HI || cmd.mul_sel == MUL_VAR_HI
          || cmd.mul_sel == MUL_SQ_HI) begin
         addend = {prod_ff[ACC_W-33:0], 32'd0};
      end else begin
         addend = {{(ACC_W-VAR_W){1'b0}}, prod_ff};
      end
      acc_in = acc_ff + addend;
   end

   // mean: restore the sign of alpha*|dx|, round half up, drop 16 bits
   always_comb begin
      macc    = dx_ff[DX_W-1] ? $signed(~acc_ff + ACC_W'(1)) : $signed(acc_ff);
      mrnd    = (macc + $signed(ACC_W'(32768))) >>> 16;
      mean_in = mean_ff + mrnd[SAMPLE_WIDTH-1:0];
   end

   // variance: saturate the rounded weighted sum
   always_comb begin
      var_in   = (acc_ff[ACC_W-1:VAR_W+16] != '0) ? '1 : acc_ff[VAR_W+15:16];
      count_in = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   end

   // one restoring square root step, two radicand bits at a time
   always_comb begin
      cur   = {rem_ff, rad_ff[VAR_W-1:VAR_W-2]};
      trial = {2'b00, root_ff, 2'b01};
      sub   = cur - trial;
      if (cur >= trial) begin
         rem_in  = sub[DEV_W+1:0];
         root_in = {root_ff[DEV_W-2:0], 1'b1};
      end else begin
         rem_in  = cur[DEV_W+1:0];
         root_in = {root_ff[DEV_W-2:0], 1'b0};
      end
   end

   // threshold: only a non-negative term is added, so clip the top only
   always_comb begin
      lim_sum  = $signed({{(SUM_W-SAMPLE_WIDTH){mean_ff[SAMPLE_WIDTH-1]}}, mean_ff})
               + $signed({{(SUM_W-SCL_W){1'b0}}, prod_ff[SCL_W+7:8]});
      smax_ext = $signed({{(SUM_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}});
      lim_in   = (lim_sum > smax_ext) ? {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}
                                      : lim_sum[SAMPLE_WIDTH-1:0];
   end

   // configuration and estimator state
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= 16'd66;
         mult_ff   <= 16'd512;
         warmup_ff <= 16'd1000;
         floor_ff  <= 32'd1;
         mean_ff   <= '0;
         var_ff    <= '0;
         count_ff  <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_SMOOTHING:  alpha_ff  <= csr_data[WEIGHT_W-1:0];
               REG_MULTIPLIER: mult_ff   <= csr_data[WEIGHT_W-1:0];
               REG_WARMUP:     warmup_ff <= csr_data[WEIGHT_W-1:0];
               REG_FLOOR:      floor_ff  <= csr_data[DEV_W-1:0];
               default:        ;
            endcase
         end
         if (cmd.mean_upd) begin
            mean_ff <= mean_in;
         end
         if (cmd.var_upd) begin
            var_ff   <= var_in;
            count_ff <= count_in;
         end
      end
   end

   // working and output registers
   always_ff @(posedge clock) begin
      if (cmd.ld) begin
         x_ff    <= in_sample;
         tick_ff <= in_tick;
         rad_ff  <= var_ff;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff  <= {rad_ff[VAR_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
      if (cmd.diff) begin
         dx_ff  <= dx_in;
         mag_ff <= mag_in;
         acc_ff <= '0;
      end else if (cmd.acc_go) begin
         acc_ff <= acc_in;
      end else if (cmd.mean_upd) begin
         acc_ff <= ACC_W'(32768);
      end
      if (cmd.mul_go) begin
         prod_ff <= prod_in;
      end
      if (cmd.sq_ld) begin
         sq_ff <= (mag64[63:32] != 32'd0) ? '1 : prod_ff;
      end
      if (cmd.dev_ld) begin
         dev_ff <= (root_ff < floor_ff) ? floor_ff : root_ff;
      end
      if (cmd.out_ld) begin
         o_tick_ff <= tick_ff;
         o_mean_ff <= mean_ff;
         o_dev_ff  <= dev_ff;
         o_lim_ff  <= lim_in;
         o_warm_ff <= (count_ff >= warmup_ff);
      end
   end

   assign out_tick  = o_tick_ff;
   assign out_mean  = o_mean_ff;
   assign out_dev   = o_dev_ff;
   assign out_limit = o_lim_ff;
   assign out_warm  = o_warm_ff;

endmodule

// ===== src/ewmv_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ewmv_checker
// Port-level checks on the tracker, bound to the top level.
// ---------------------------------------------------------------------------
`include "ewma_mean_variance_threshold_macros.svh"

module ewmv_checker #(
   parameter int SAMPLE_WIDTH = 32,
   localparam int RSP_W = ((2 * SAMPLE_WIDTH + 97 + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             req_tuser,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);
   localparam int MEAN_LSB = 64;
   localparam int LIM_LSB  = 64 + SAMPLE_WIDTH + 32;

   // a held report must not change
   `EWMV_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "report changed while stalled")

   // one word at a time: no acceptance right after an acceptance
   `EWMV_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "word accepted while busy")

   // a sample never yields a report
   `EWMV_ASSERT_NEXT(a_sample_silent, req_tvalid && req_tready && !req_tuser && !rsp_tvalid, !rsp_tvalid, "report appeared after a sample")

   // the threshold never lies below the mean
   `EWMV_ASSERT_SAME(a_limit_above_mean, rsp_tvalid, $signed(rsp_tdata[LIM_LSB +: SAMPLE_WIDTH]) >= $signed(rsp_tdata[MEAN_LSB +: SAMPLE_WIDTH]), "threshold below mean")

endmodule

bind ewma_mean_variance_threshold ewmv_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_ewmv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the moving mean / variance threshold block. A
// tracker inside the bench follows every accepted sample and predicts the
// report for every tick; the monitor checks each report field by field. The
// stimulus covers directed corners, register extremes and random streams.
// ---------------------------------------------------------------------------
module testbench;
   import ewmv_pkg::*;

   localparam int REQ_BITS       = 96;   // sample [31:0], tick_number [95:32]
   localparam int RSP_BITS       = 168;  // see the unpacking in the monitor
   localparam int CLOCK_HALF     = 5;
   localparam int WATCHDOG_LIMIT = 2000; // quiet cycles before giving up
   localparam int SETTLE_CYCLES  = 48;   // outlasts a tick's pass through the block
   localparam int LONG_HOLD      = 400;  // receiver back-pressure stretch
   localparam int PRINT_CAP      = 40;
   localparam longint SAMPLE_MAX = 64'sd2147483647;
   localparam longint SAMPLE_MIN = -64'sd2147483648;
   localparam logic [16:0] UNITY_WEIGHT = 17'h10000;  // 1.0 in Q0.16
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 4'd9;

   typedef enum logic {ACT_SAMPLE = 1'b0, ACT_TICK = 1'b1} action_type;

   typedef struct {
      action_type  action;
      logic [31:0] sample;
      logic [63:0] tick_id;
      bit          drain;    // hold back until every report has come
   } request_word_type;

   typedef struct {
      logic [63:0] tick_id;
      logic [31:0] mean;
      logic [31:0] sigma;
      logic [31:0] limit;
      logic        warm;
   } report_type;

   // every input starts at a known value
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_BITS-1:0]  req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]  rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_DAT_W-1:0] csr_data   = '0;

   // shadow registers, at their reset values
   logic [15:0] cfg_alpha  = 16'd66;
   logic [15:0] cfg_mult   = 16'd512;
   logic [15:0] cfg_warmup = 16'd1000;
   logic [31:0] cfg_floor  = 32'd1;

   // tracker state
   logic signed [31:0] trk_mean  = '0;
   logic [63:0]        trk_var   = '0;
   logic [15:0]        trk_count = '0;

   request_word_type pending_words[$];
   report_type       report_queue[$];
   request_word_type offered;

   int words_issued = 0, words_taken = 0, ticks_taken = 0;
   int reports_checked = 0, error_count = 0, csr_writes = 0;
   int send_idle_pct = 25, recv_idle_pct = 25;
   int send_gap = 0, recv_gap = 0, stall_left = 0, quiet_cycles = 0;
   bit hold_off_request = 1'b0;

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   ewma_mean_variance_threshold u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Integer square root: set result bits from the top while the square
   // still fits under the operand.
   function automatic logic [31:0] root_of(input logic [63:0] v);
      logic [31:0] r;
      logic [31:0] cand;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         cand = r | (32'd1 << b);
         if (64'(cand) * 64'(cand) <= v) r = cand;
      end
      return r;
   endfunction

   // Advance the tracker by one accepted word; a tick queues its report.
   function automatic void track_word(input request_word_type w);
      longint      dx, step, lim_wide;
      logic [63:0] mag, sq, boost;
      logic [81:0] keep_part, take_part, mixed;
      logic [31:0] sig;
      report_type  r;
      if (w.action == ACT_SAMPLE) begin
         dx = $signed({{32{w.sample[31]}}, w.sample})
            - $signed({{32{trk_mean[31]}}, trk_mean});
         // mean moves by alpha * dx, rounded half up; an arithmetic shift floors
         step = ($signed({48'd0, cfg_alpha}) * dx + 64'sd32768) >>> 16;
         trk_mean = trk_mean + step[31:0];
         mag = (dx < 0) ? -dx : dx;
         sq  = (mag > 64'hFFFF_FFFF) ? '1 : mag * mag;
         // exact weighted blend of the old variance and the squared deviation
         keep_part = 82'(UNITY_WEIGHT - {1'b0, cfg_alpha}) * 82'(trk_var);
         take_part = 82'(cfg_alpha) * 82'(sq);
         mixed     = (keep_part + take_part + 82'd32768) >> 16;
         trk_var   = (|mixed[81:64]) ? '1 : mixed[63:0];
         if (trk_count != 16'hFFFF) trk_count++;
      end else begin
         sig = root_of(trk_var);
         if (sig < cfg_floor) sig = cfg_floor;
         boost    = (64'(cfg_mult) * 64'(sig)) >> 8;
         lim_wide = $signed({{32{trk_mean[31]}}, trk_mean}) + $signed(boost);
         if (lim_wide > SAMPLE_MAX)      r.limit = SAMPLE_MAX[31:0];
         else if (lim_wide < SAMPLE_MIN) r.limit = SAMPLE_MIN[31:0];
         else                            r.limit = lim_wide[31:0];
         r.tick_id = w.tick_id;
         r.mean    = trk_mean;
         r.sigma   = sig;
         r.warm    = (trk_count >= cfg_warmup);
         report_queue.insert(report_queue.size(), r);
      end
   endfunction

   task automatic flag_error(input string what, input logic [63:0] got,
                             input logic [63:0] want);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
   endtask

   function automatic void queue_word(input action_type act, input logic [31:0] value,
                                      input logic [63:0] id, input bit drain);
      request_word_type w;
      w.action  = act;
      w.sample  = value;
      w.tick_id = id;
      w.drain   = drain;
      pending_words.insert(pending_words.size(), w);
      words_issued++;
   endfunction

   // Random mix of ticks and samples. Samples are full range, close to the
   // current mean (so that the deviation floor matters), at the extremes, or
   // small magnitudes of either sign.
   function automatic void queue_random(input int count, input int tick_pct);
      logic [31:0] v;
      bit          s;
      repeat (count) begin
         if ($urandom_range(99) < tick_pct) begin
            queue_word(ACT_TICK, $urandom, {$urandom, $urandom}, $urandom_range(29) == 0);
         end else begin
            s = $urandom_range(1);
            case ($urandom_range(9))
               0, 1, 2, 3: v = $urandom;
               4, 5, 6, 7: v = trk_mean + 32'($urandom_range(8191)) - 32'd4096;
               8:          v = s ? 32'h7FFF_FFFF : 32'h8000_0000;
               default:    v = {{16{s}}, 16'($urandom)};
            endcase
            queue_word(ACT_SAMPLE, v, {$urandom, $urandom}, 1'b0);
         end
      end
   endfunction

   // Wait until every word is taken and every report has come, then let the
   // block finish any sample still in flight.
   task automatic wait_drained();
      while (words_taken != words_issued || report_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         REG_SMOOTHING:  cfg_alpha  = value[15:0];
         REG_MULTIPLIER: cfg_mult   = value[15:0];
         REG_WARMUP:     cfg_warmup = value[15:0];
         REG_FLOOR:      cfg_floor  = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [15:0] alpha, input logic [15:0] mult,
                                 input logic [15:0] warmup, input logic [31:0] floor_v);
      write_reg(REG_SMOOTHING, 32'(alpha));
      write_reg(REG_MULTIPLIER, 32'(mult));
      write_reg(REG_WARMUP, 32'(warmup));
      write_reg(REG_FLOOR, floor_v);
   endtask

   // Driver: predict on acceptance, then offer the next pending word unless
   // idling or a drain point is waiting for the reports to come back.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_word(offered);
            words_taken++;
            if (offered.action == ACT_TICK) ticks_taken++;
         end
         // hold the word while it is refused
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() == 0
                         || (pending_words[0].drain && report_queue.size() != 0)) begin
               req_tvalid <= 1'b0;
            end else if ($urandom_range(99) < send_idle_pct) begin
               send_gap = $urandom_range(11);
               req_tvalid <= 1'b0;
            end else begin
               offered = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= offered.action;
               req_tdata  <= {offered.tick_id, offered.sample};
            end
         end
      end
   end

   // Monitor: check each accepted report against the oldest prediction and
   // drive the receiver's ready with bursts of back-pressure.
   always @(posedge clock) begin : receive
      report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (report_queue.size() == 0) begin
               flag_error("report with none expected", rsp_tdata[63:0], '0);
            end else begin
               want = report_queue.pop_front();
               reports_checked++;
               // report_tick [63:0], mean [95:64], deviation [127:96],
               // limit [159:128], warm [160]
               if (rsp_tdata[63:0] !== want.tick_id)
                  flag_error("report_tick", rsp_tdata[63:0], want.tick_id);
               if (rsp_tdata[95:64] !== want.mean)
                  flag_error("mean_value", 64'(rsp_tdata[95:64]), 64'(want.mean));
               if (rsp_tdata[127:96] !== want.sigma)
                  flag_error("deviation", 64'(rsp_tdata[127:96]), 64'(want.sigma));
               if (rsp_tdata[159:128] !== want.limit)
                  flag_error("limit_value", 64'(rsp_tdata[159:128]), 64'(want.limit));
               if (rsp_tdata[160] !== want.warm)
                  flag_error("warm", 64'(rsp_tdata[160]), 64'(want.warm));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (hold_off_request) begin
            // long stretch: the block must fill up and refuse request words
            hold_off_request = 1'b0;
            stall_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(99) < recv_idle_pct) begin
            recv_gap = $urandom_range(11);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: give up when nothing moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: report from the empty state, both sample extremes,
      // tick ids at zero and all ones, a drain point before the last tick.
      queue_word(ACT_TICK, $urandom, 64'd0, 1'b0);
      queue_word(ACT_TICK, $urandom, '1, 1'b0);
      queue_word(ACT_SAMPLE, 32'h7FFF_FFFF, {$urandom, $urandom}, 1'b0);
      queue_word(ACT_SAMPLE, 32'h8000_0000, {$urandom, $urandom}, 1'b0);
      queue_word(ACT_TICK, $urandom, 64'h5555_5555_5555_5555, 1'b0);
      queue_word(ACT_SAMPLE, 32'h0000_0000, {$urandom, $urandom}, 1'b0);
      queue_word(ACT_SAMPLE, 32'hFFFF_FFFF, {$urandom, $urandom}, 1'b0);
      queue_word(ACT_SAMPLE, 32'h0001_0000, {$urandom, $urandom}, 1'b0);
      queue_word(ACT_SAMPLE, 32'hFFFF_0000, {$urandom, $urandom}, 1'b0);
      queue_word(ACT_TICK, $urandom, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      hold_off_request = 1'b1;
      queue_random(100, 35);
      wait_drained();

      // Everything at its top end, warmup zero so warm is always set; the
      // maximum floor drives the threshold into saturation. Drop a write to
      // an unmapped index on the way.
      apply_settings(16'hFFFF, 16'hFFFF, 16'd0, 32'hFFFF_FFFF);
      write_reg(REG_UNMAPPED, $urandom);
      send_idle_pct = 10;
      recv_idle_pct = 40;
      queue_word(ACT_TICK, $urandom, {$urandom, $urandom}, 1'b0);
      queue_word(ACT_SAMPLE, 32'h7FFF_FFFF, {$urandom, $urandom}, 1'b0);
      queue_word(ACT_TICK, $urandom, {$urandom, $urandom}, 1'b0);
      queue_word(ACT_SAMPLE, 32'h8000_0000, {$urandom, $urandom}, 1'b0);
      queue_word(ACT_TICK, $urandom, {$urandom, $urandom}, 1'b0);
      queue_word(ACT_SAMPLE, 32'h0000_0000, {$urandom, $urandom}, 1'b0);
      queue_word(ACT_TICK, $urandom, {$urandom, $urandom}, 1'b0);
      wait_drained();
      write_reg(REG_FLOOR, 32'd0);
      queue_random(80, 40);
      wait_drained();

      // Random settings; put the warmup just ahead of the count so that
      // warm changes within the stream.
      repeat (3) begin
         send_idle_pct = $urandom_range(40);
         recv_idle_pct = $urandom_range(40);
         apply_settings($urandom_range(1) ? 16'($urandom_range(1, 2048)) : 16'($urandom),
                        16'($urandom),
                        16'(trk_count + $urandom_range(40)),
                        $urandom_range(1) ? 32'($urandom_range(1 << 20)) : $urandom);
         queue_random(90, 30);
         wait_drained();
      end

      // Zero weight: samples only advance the count, the mean and variance
      // hold. Then a short burst with no idling.
      apply_settings(16'd0, 16'd0, 16'hFFFF, 32'd0);
      send_idle_pct = 20;
      recv_idle_pct = 20;
      queue_random(50, 30);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_word(ACT_TICK, $urandom, {$urandom, $urandom}, 1'b0);
      queue_word(ACT_SAMPLE, $urandom, {$urandom, $urandom}, 1'b0);
      queue_word(ACT_TICK, $urandom, {$urandom, $urandom}, 1'b0);
      queue_word(ACT_SAMPLE, $urandom, {$urandom, $urandom}, 1'b0);
      queue_word(ACT_SAMPLE, $urandom, {$urandom, $urandom}, 1'b0);
      queue_word(ACT_TICK, $urandom, {$urandom, $urandom}, 1'b0);
      wait_drained();

      // Closing stretch without idling on either side.
      apply_settings(16'($urandom_range(1, 65535)), 16'd256, 16'd0, 32'd1);
      queue_random(60, 35);
      wait_drained();

      if (report_queue.size() != 0)
         flag_error("reports never delivered", 64'(report_queue.size()), '0);
      $display("Covered %0d request words (%0d ticks), %0d reports checked, %0d register writes,",
               words_taken, ticks_taken, reports_checked, csr_writes);
      $display("register extremes, zero weight, drain points and long back-pressure.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
